FILE: rtl/mprc_pkg.sv
// ---------------------------------------------------------------------------
// mprc_pkg
// Shared types and constants for the masked pixel to RGBA8 converter.
// ---------------------------------------------------------------------------
package mprc_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned STR_W   = 18;
  localparam int unsigned ROWW_W  = 15;
  localparam int unsigned BIR_W   = 17;
  localparam int unsigned PBITS_W = 7;
  localparam int unsigned IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_RED    = 3'd0;
  localparam logic [IDX_W-1:0] REG_GREEN  = 3'd1;
  localparam logic [IDX_W-1:0] REG_BLUE   = 3'd2;
  localparam logic [IDX_W-1:0] REG_ALPHA  = 3'd3;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd4;
  localparam logic [IDX_W-1:0] REG_STRIDE = 3'd5;
  localparam logic [IDX_W-1:0] REG_PBITS  = 3'd6;
  localparam logic [IDX_W-1:0] REG_BENDN  = 3'd7;

  localparam logic [STR_W-1:0] STRIDE_MAX = 18'd131072;

  typedef struct packed {
    logic [WORD_W-1:0]  red_mask;
    logic [WORD_W-1:0]  green_mask;
    logic [WORD_W-1:0]  blue_mask;
    logic [WORD_W-1:0]  alpha_mask;
    logic [ROWW_W-1:0]  row_width;
    logic [STR_W-1:0]   row_stride_bytes;
    logic [PBITS_W-1:0] pixel_bits;
    logic               big_endian;
  } cfg_t;

  // One pixel waiting for channel extraction
  typedef struct packed {
    logic [WORD_W-1:0] pix;
    logic              narrow;
    logic              row_end;
    logic              last;
  } pix_item_t;

endpackage

FILE: rtl/masked_pixel_to_rgba8_converter.sv
// ---------------------------------------------------------------------------
// masked_pixel_to_rgba8_converter
// Raw bitfield pixel bytes in, RGBA8888 pixels out, one result per pixel.
// ---------------------------------------------------------------------------
// Channel  Handshake          Payload
// in       in_valid/ready     in_data_byte, in_start_of_image
// out      out_valid/ready    out_red/green/blue/alpha, out_row_end, out_last_of_run
// cfg      cfg_we             cfg_index, cfg_wdata
//
// A byte is taken on each in handshake; 1, 2 and 4 bit modes then hold
// in_ready low while the byte's pixels are unpacked. In the back end each
// pixel is popped and each channel in turn passes setup, a 6-step normalise,
// one multiply, an 8-step divide and a round (a zero mask gives its default
// at setup); the output register is loaded when free. A two-entry queue
// separates the two parts, so either side may stall alone.
// Reset is synchronous and active low; no clearing pass is needed.
module masked_pixel_to_rgba8_converter #(
  parameter int unsigned MAX_WIDTH = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_image,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        out_row_end,
  output logic        out_last_of_run
);

  mprc_pkg::cfg_t      cfg_r;
  mprc_pkg::pix_item_t push_item, pop_item;
  logic                q_full, q_push, q_pop, q_not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red_mask         <= '0;
      cfg_r.green_mask       <= '0;
      cfg_r.blue_mask        <= '0;
      cfg_r.alpha_mask       <= '0;
      cfg_r.row_width        <= 15'd1;
      cfg_r.row_stride_bytes <= 18'd1;
      cfg_r.pixel_bits       <= 7'd8;
      cfg_r.big_endian       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mprc_pkg::REG_RED:    cfg_r.red_mask         <= cfg_wdata;
        mprc_pkg::REG_GREEN:  cfg_r.green_mask       <= cfg_wdata;
        mprc_pkg::REG_BLUE:   cfg_r.blue_mask        <= cfg_wdata;
        mprc_pkg::REG_ALPHA:  cfg_r.alpha_mask       <= cfg_wdata;
        mprc_pkg::REG_WIDTH:  cfg_r.row_width        <= cfg_wdata[14:0];
        mprc_pkg::REG_STRIDE: cfg_r.row_stride_bytes <= cfg_wdata[17:0];
        mprc_pkg::REG_PBITS:  cfg_r.pixel_bits       <= cfg_wdata[6:0];
        mprc_pkg::REG_BENDN:  cfg_r.big_endian       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  mprc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_start_of_image (in_start_of_image),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_item            (push_item)
  );

  mprc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_item   (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_item   (pop_item)
  );

  mprc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_not_empty     (q_not_empty),
    .q_item          (pop_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_row_end     (out_row_end),
    .out_last_of_run (out_last_of_run)
  );

endmodule

FILE: rtl/mprc_front.sv
// ---------------------------------------------------------------------------
// mprc_front
// Byte intake: row and stride tracking, pixel assembly and sub-byte unpacking.
// ---------------------------------------------------------------------------
module mprc_front #(
  parameter int unsigned MAX_WIDTH = 16384
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mprc_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_start_of_image,
  input  logic                q_full,
  output logic                q_push,
  output mprc_pkg::pix_item_t q_item
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                       state_r, state_nxt;
  logic [63:0]                pa_r, pa_nxt;
  logic [2:0]                 bip_r, bip_nxt;
  logic [mprc_pkg::BIR_W-1:0] bir_r, bir_nxt;
  logic [14:0]                pir_r, pir_nxt;
  logic [7:0]                 byte_r, byte_nxt;
  logic [3:0]                 left_r, left_nxt;

  logic [14:0]                width;
  logic [mprc_pkg::STR_W-1:0] stride;
  logic                       is_narrow, is_whole;
  logic [3:0]                 bits4;
  logic [7:0]                 fmask;

  always_comb begin
    if ({2'b00, cfg.row_width} > 17'(MAX_WIDTH)) width = 15'(MAX_WIDTH);
    else width = cfg.row_width;
    if (cfg.row_stride_bytes == '0) stride = 18'd1;
    else if (cfg.row_stride_bytes > mprc_pkg::STRIDE_MAX) stride = mprc_pkg::STRIDE_MAX;
    else stride = cfg.row_stride_bytes;
    is_narrow = (cfg.pixel_bits == 7'd1) || (cfg.pixel_bits == 7'd2) ||
                (cfg.pixel_bits == 7'd4);
    is_whole  = (cfg.pixel_bits >= 7'd8) && (cfg.pixel_bits <= 7'd64) &&
                (cfg.pixel_bits[2:0] == 3'd0);
    bits4 = cfg.pixel_bits[3:0];
    fmask = 8'((9'd1 << bits4) - 9'd1);
  end

  assign in_ready = (state_r == ST_IDLE) && !q_full;

  always_comb begin
    logic [63:0]                pa;
    logic [2:0]                 bip;
    logic [mprc_pkg::BIR_W-1:0] bir;
    logic [14:0]                pir, pir1;
    logic [3:0]                 lft, nbm1;
    logic [mprc_pkg::STR_W-1:0] bir1;
    logic                       step_done;
    state_nxt = state_r;
    pa_nxt    = pa_r;
    bip_nxt   = bip_r;
    bir_nxt   = bir_r;
    pir_nxt   = pir_r;
    byte_nxt  = byte_r;
    left_nxt  = left_r;
    q_push    = 1'b0;
    q_item    = '0;
    pa  = pa_r;
    bip = bip_r;
    bir = bir_r;
    pir = pir_r;
    pir1 = '0;
    lft  = '0;
    bir1 = '0;
    nbm1 = cfg.pixel_bits[6:3] - 4'd1;
    step_done = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_start_of_image) begin
            pa  = '0;
            bip = '0;
            bir = '0;
            pir = '0;
          end
          step_done = 1'b1;
          if (pir < width) begin
            if (is_narrow) begin
              byte_nxt  = in_data_byte;
              left_nxt  = 4'd8;
              state_nxt = ST_EMIT;
              step_done = 1'b0;
            end else if (is_whole) begin
              if (cfg.big_endian) pa = {pa[55:0], in_data_byte};
              else pa = pa | ({56'd0, in_data_byte} << {bip, 3'b000});
              if ({1'b0, bip} >= nbm1) begin
                pir1           = pir + 15'd1;
                q_push         = 1'b1;
                q_item.pix     = pa;
                q_item.narrow  = 1'b0;
                q_item.row_end = (pir1 == width);
                q_item.last    = 1'b1;
                pir = pir1;
                pa  = '0;
                bip = '0;
              end else begin
                bip = bip + 3'd1;
              end
            end
          end
        end
      end
      ST_EMIT: begin
        if (!q_full) begin
          lft  = left_r - bits4;
          pir1 = pir_r + 15'd1;
          q_push         = 1'b1;
          q_item.pix     = {56'd0, (byte_r >> lft) & fmask};
          q_item.narrow  = 1'b1;
          q_item.row_end = (pir1 == width);
          q_item.last    = (lft == 4'd0) || (pir1 == width);
          pir      = pir1;
          left_nxt = lft;
          if (q_item.last) begin
            step_done = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (step_done) begin
      // advance the stride position once the byte is finished
      bir1 = {1'b0, bir} + 18'd1;
      if (bir1 >= stride) begin
        bir = '0;
        pir = '0;
        bip = '0;
        pa  = '0;
      end else begin
        bir = bir1[mprc_pkg::BIR_W-1:0];
      end
    end
    if (state_r == ST_EMIT || (in_valid && in_ready)) begin
      pa_nxt  = pa;
      bip_nxt = bip;
      bir_nxt = bir;
      pir_nxt = pir;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pa_r    <= '0;
      bip_r   <= '0;
      bir_r   <= '0;
      pir_r   <= '0;
      left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pa_r    <= pa_nxt;
      bip_r   <= bip_nxt;
      bir_r   <= bir_nxt;
      pir_r   <= pir_nxt;
      left_r  <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

FILE: rtl/mprc_queue.sv
// ---------------------------------------------------------------------------
// mprc_queue
// Two-entry pixel queue between the byte front and the channel back end.
// ---------------------------------------------------------------------------
module mprc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mprc_pkg::pix_item_t wr_item,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output mprc_pkg::pix_item_t rd_item
);

  mprc_pkg::pix_item_t mem_r [2];
  logic                wp_r, rp_r;
  logic [1:0]          cnt_r;
  logic                do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr_item;
  end

endmodule

FILE: rtl/mprc_back.sv
// ---------------------------------------------------------------------------
// mprc_back
// Channel extraction: mask, normalise, scale by 255, divide by the mask range and round.
// ---------------------------------------------------------------------------
module mprc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mprc_pkg::cfg_t      cfg,
  input  logic                q_not_empty,
  input  mprc_pkg::pix_item_t q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue,
  output logic [7:0]          out_alpha,
  output logic                out_row_end,
  output logic                out_last_of_run
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_NORM  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_ROUND = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [1:0]          ch_r, ch_nxt;
  logic [2:0]          step_r, step_nxt;
  mprc_pkg::pix_item_t item_r, item_nxt;
  logic [63:0]         val_r, val_nxt;
  logic [63:0]         msk_r, msk_nxt;
  logic [71:0]         rem_r, rem_nxt;
  logic [7:0]          q_r, q_nxt;
  logic [7:0]          res_r [4];
  logic [7:0]          res_val;
  logic                res_we;
  logic                ov_r, ov_nxt;
  logic [7:0]          ored_r, ogrn_r, oblu_r, oalp_r;
  logic                orow_r, olast_r;
  logic                load_out;

  logic [63:0] cur_mask;
  always_comb begin
    case (ch_r)
      2'd0:    cur_mask = cfg.red_mask;
      2'd1:    cur_mask = cfg.green_mask;
      2'd2:    cur_mask = cfg.blue_mask;
      default: cur_mask = cfg.alpha_mask;
    endcase
    if (item_r.narrow) cur_mask = {56'd0, cur_mask[7:0]};
  end

  always_comb begin
    logic [6:0]  sh;
    logic [63:0] lowm;
    logic [71:0] dv;
    logic [64:0] r2;
    logic [8:0]  q9;
    state_nxt = state_r;
    ch_nxt    = ch_r;
    step_nxt  = step_r;
    item_nxt  = item_r;
    val_nxt   = val_r;
    msk_nxt   = msk_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    res_we    = 1'b0;
    res_val   = '0;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    ov_nxt    = ov_r && !out_ready;
    sh   = 7'd32 >> step_r;
    lowm = (64'd1 << sh) - 64'd1;
    dv   = {8'd0, msk_r} << step_r;
    r2   = {rem_r[63:0], 1'b0};
    q9   = '0;
    case (state_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          q_pop     = 1'b1;
          item_nxt  = q_item;
          ch_nxt    = 2'd0;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (cur_mask == '0) begin
          res_we  = 1'b1;
          res_val = (ch_r == 2'd3) ? 8'd255 : 8'd0;
          ch_nxt  = ch_r + 2'd1;
          if (ch_r == 2'd3) state_nxt = ST_OUT;
        end else begin
          val_nxt   = item_r.pix & cur_mask;
          msk_nxt   = cur_mask;
          step_nxt  = 3'd0;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        // drop trailing zeros of the mask, halving the shift at each step
        if ((msk_r & lowm) == '0) begin
          msk_nxt = msk_r >> sh;
          val_nxt = val_r >> sh;
        end
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd5) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        rem_nxt   = ({8'd0, val_r} << 8) - {8'd0, val_r};
        step_nxt  = 3'd7;
        q_nxt     = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (rem_r >= dv) begin
          rem_nxt         = rem_r - dv;
          q_nxt[step_r]   = 1'b1;
        end
        step_nxt = step_r - 3'd1;
        if (step_r == 3'd0) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        q9 = {1'b0, q_r} + {8'd0, (r2 >= {1'b0, msk_r})};
        res_we  = 1'b1;
        res_val = q9[8] ? 8'd255 : q9[7:0];
        ch_nxt  = ch_r + 2'd1;
        state_nxt = (ch_r == 2'd3) ? ST_OUT : ST_SETUP;
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          load_out  = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= '0;
      step_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      step_r  <= step_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    val_r  <= val_nxt;
    msk_r  <= msk_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    if (res_we) res_r[ch_r] <= res_val;
    if (load_out) begin
      ored_r  <= res_r[0];
      ogrn_r  <= res_r[1];
      oblu_r  <= res_r[2];
      oalp_r  <= res_r[3];
      orow_r  <= item_r.row_end;
      olast_r <= item_r.last;
    end
  end

  assign out_valid       = ov_r;
  assign out_red         = ored_r;
  assign out_green       = ogrn_r;
  assign out_blue        = oblu_r;
  assign out_alpha       = oalp_r;
  assign out_row_end     = orow_r;
  assign out_last_of_run = olast_r;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Byte stream tests for the masked pixel to RGBA8 converter: a pixel model
// fed with the same bytes and registers predicts each RGBA pixel, and every
// pixel transfer is checked field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb;

  localparam int unsigned WIDTH_SAT = 16384;
  localparam int unsigned WDOG_MAX  = 20000;
  localparam int unsigned SETTLE    = 100;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;
    logic       last_of_run;
  } rgba_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_start_of_image = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red, out_green, out_blue, out_alpha;
  logic        out_row_end, out_last_of_run;

  masked_pixel_to_rgba8_converter uut (.*);

  always #5 clk = ~clk;

  // pixel model state
  mprc_pkg::cfg_t mcfg;
  logic [63:0]    asm_word;
  int unsigned    asm_byte, row_byte, row_pix;
  rgba_t          rgba_q[$];
  bit             failed = 1'b0;
  int unsigned    idle_cycles = 0;

  function automatic logic [7:0] scale255(logic [63:0] v, logic [63:0] mx);
    logic [71:0] q;
    logic [71:0] r;
    q = ({8'd0, v} * 72'd255) / {8'd0, mx};
    r = ({8'd0, v} * 72'd255) % {8'd0, mx};
    if (r >= {8'd0, mx} - r) q = q + 1;
    return (q > 72'd255) ? 8'd255 : q[7:0];
  endfunction

  function automatic logic [7:0] channel_of(logic [63:0] pix, logic [63:0] m,
                                            logic [7:0] none);
    int sh;
    if (m == '0) return none;
    sh = 0;
    while (!m[sh]) sh++;
    return scale255((pix & m) >> sh, m >> sh);
  endfunction

  function automatic logic [63:0] field_mask(int unsigned len, int unsigned pos);
    logic [63:0] m;
    m = (len >= 64) ? '1 : ((64'd1 << len) - 64'd1);
    return m << pos;
  endfunction

  task automatic push_pixel(logic [63:0] pix, bit narrow, int unsigned wd);
    logic [63:0] lm;
    rgba_t p;
    lm = narrow ? 64'hFF : '1;
    row_pix++;
    p.red = channel_of(pix, mcfg.red_mask & lm, 8'd0);
    p.green = channel_of(pix, mcfg.green_mask & lm, 8'd0);
    p.blue = channel_of(pix, mcfg.blue_mask & lm, 8'd0);
    p.alpha = channel_of(pix, mcfg.alpha_mask & lm, 8'd255);
    p.row_end = (row_pix == wd);
    p.last_of_run = 1'b0;
    rgba_q.push_back(p);
  endtask

  task automatic predict_byte(logic [7:0] d, bit soi);
    int unsigned wd, st, left, nb, k;
    wd = (mcfg.row_width > WIDTH_SAT) ? WIDTH_SAT : mcfg.row_width;
    st = (mcfg.row_stride_bytes == 0) ? 1 : mcfg.row_stride_bytes;
    if (st > mprc_pkg::STRIDE_MAX) st = mprc_pkg::STRIDE_MAX;
    k = 0;
    if (soi) begin
      asm_word = '0;
      asm_byte = 0;
      row_byte = 0;
      row_pix = 0;
    end
    if (row_pix < wd) begin
      if (mcfg.pixel_bits == 1 || mcfg.pixel_bits == 2 || mcfg.pixel_bits == 4) begin
        left = 8;
        while (left > 0 && row_pix < wd) begin
          left -= mcfg.pixel_bits;
          push_pixel(64'((d >> left) & ((8'd1 << mcfg.pixel_bits) - 8'd1)), 1'b1, wd);
          k++;
        end
      end else if (mcfg.pixel_bits >= 8 && mcfg.pixel_bits <= 64
                   && mcfg.pixel_bits[2:0] == 3'd0) begin
        nb = mcfg.pixel_bits >> 3;
        if (mcfg.big_endian) asm_word = (asm_word << 8) | 64'(d);
        else asm_word |= 64'(d) << (8 * (asm_byte & 7));
        if (asm_byte >= nb - 1) begin
          push_pixel(asm_word, 1'b0, wd);
          k++;
          asm_word = '0;
          asm_byte = 0;
        end else begin
          asm_byte = (asm_byte + 1) & 7;
        end
      end
    end
    row_byte++;
    if (row_byte >= st) begin
      row_byte = 0;
      row_pix = 0;
      asm_byte = 0;
      asm_word = '0;
    end
    if (k > 0) rgba_q[rgba_q.size()-1].last_of_run = 1'b1;
  endtask

  // called and returns at a falling edge; hold off until nothing is in flight
  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    in_valid <= 1'b0;
    while (rgba_q.size() != 0) @(negedge clk);
    case (idx)
      mprc_pkg::REG_RED:    mcfg.red_mask = val;
      mprc_pkg::REG_GREEN:  mcfg.green_mask = val;
      mprc_pkg::REG_BLUE:   mcfg.blue_mask = val;
      mprc_pkg::REG_ALPHA:  mcfg.alpha_mask = val;
      mprc_pkg::REG_WIDTH:  mcfg.row_width = val[mprc_pkg::ROWW_W-1:0];
      mprc_pkg::REG_STRIDE: mcfg.row_stride_bytes = val[mprc_pkg::STR_W-1:0];
      mprc_pkg::REG_PBITS:  mcfg.pixel_bits = val[mprc_pkg::PBITS_W-1:0];
      mprc_pkg::REG_BENDN:  mcfg.big_endian = val[0];
      default: ;
    endcase
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_format(logic [63:0] r, logic [63:0] g, logic [63:0] b,
                            logic [63:0] a, int unsigned wd, int unsigned st,
                            int unsigned pb, bit be);
    cfg_write(mprc_pkg::REG_RED, r);
    cfg_write(mprc_pkg::REG_GREEN, g);
    cfg_write(mprc_pkg::REG_BLUE, b);
    cfg_write(mprc_pkg::REG_ALPHA, a);
    cfg_write(mprc_pkg::REG_WIDTH, 64'(wd));
    cfg_write(mprc_pkg::REG_STRIDE, 64'(st));
    cfg_write(mprc_pkg::REG_PBITS, 64'(pb));
    cfg_write(mprc_pkg::REG_BENDN, 64'(be));
  endtask

  // one byte transfer, then a random gap; returns at a falling edge
  task automatic send_byte(logic [7:0] d, bit soi);
    int unsigned gap, sel;
    predict_byte(d, soi);
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_start_of_image <= soi;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sel = $urandom_range(0, 19);
    gap = (sel < 12) ? 0 : (sel < 18) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (rgba_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // receiver: mostly ready, with the odd long stall
  int unsigned stall = 0;
  always @(negedge clk) begin
    if (stall > 0) begin
      stall--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 49) == 0) begin
      stall = $urandom_range(10, 60);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 9) < 7);
    end
  end

  always @(posedge clk) begin
    rgba_t e;
    if (rst_n && out_valid && out_ready) begin
      if (rgba_q.size() == 0) begin
        $error("pixel transfer with nothing predicted");
        failed = 1'b1;
      end else begin
        e = rgba_q.pop_front();
        if (out_red !== e.red) begin
          $error("red: expected %0d, got %0d", e.red, out_red); failed = 1'b1;
        end
        if (out_green !== e.green) begin
          $error("green: expected %0d, got %0d", e.green, out_green); failed = 1'b1;
        end
        if (out_blue !== e.blue) begin
          $error("blue: expected %0d, got %0d", e.blue, out_blue); failed = 1'b1;
        end
        if (out_alpha !== e.alpha) begin
          $error("alpha: expected %0d, got %0d", e.alpha, out_alpha); failed = 1'b1;
        end
        if (out_row_end !== e.row_end) begin
          $error("row_end: expected %0d, got %0d", e.row_end, out_row_end);
          failed = 1'b1;
        end
        if (out_last_of_run !== e.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", e.last_of_run, out_last_of_run);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WDOG_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_reset_format;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    drain();
  endtask

  task automatic test_rgb565;
    set_format(64'hF800, 64'h07E0, 64'h001F, 64'h0, 3, 8, 16, 1'b0);
    send_byte(8'h00, 1'b1); send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h10, 1'b0); send_byte(8'h84, 1'b0);
    send_byte(8'hAA, 1'b0); send_byte(8'h55, 1'b0);
    drain();
    cfg_write(mprc_pkg::REG_BENDN, 64'd1);
    send_byte(8'hF8, 1'b1); send_byte(8'h1F, 1'b0);
    // restart after a whole pixel; the last byte is left as a partial pixel
    send_byte(8'h7E, 1'b1); send_byte(8'h07, 1'b0); send_byte(8'hE0, 1'b0);
    drain();
  endtask

  task automatic test_sub_byte;
    set_format(64'h8, 64'h6, 64'h1, 64'hF0, 5, 3, 4, 1'b0);
    send_byte(8'hA5, 1'b1); send_byte(8'h3C, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h0F, 1'b0);
    cfg_write(mprc_pkg::REG_PBITS, 64'd2);
    send_byte(8'hE4, 1'b1); send_byte(8'h1B, 1'b0);
    cfg_write(mprc_pkg::REG_PBITS, 64'd1);
    set_format(64'hFFFF_FFFF_FFFF_FF01, 64'h2, 64'h0, 64'h1, 11, 2, 1, 1'b0);
    send_byte(8'h96, 1'b1); send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b0);
    drain();
  endtask

  task automatic test_wide_pixels;
    set_format('1, 64'hF0F0, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFE,
               2, 16, 64, 1'b1);
    for (int i = 0; i < 8; i++) send_byte(8'hFF, i == 0);
    for (int i = 0; i < 8; i++) send_byte(8'(8'h5A + 8'(i * 37)), 1'b0);
    drain();
    // mid-pixel depth change completes the pixel early
    set_format(64'hFF, 64'hFF00, 64'hFF_0000, 64'h0, 2, 16, 32, 1'b0);
    send_byte(8'h12, 1'b1); send_byte(8'h34, 1'b0); send_byte(8'h56, 1'b0);
    drain();
    cfg_write(mprc_pkg::REG_PBITS, 64'd16);
    send_byte(8'h78, 1'b0);
    // stride shorter than one pixel
    cfg_write(mprc_pkg::REG_PBITS, 64'd32);
    cfg_write(mprc_pkg::REG_STRIDE, 64'd3);
    send_byte(8'h01, 1'b1); send_byte(8'h02, 1'b0); send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    drain();
  endtask

  task automatic test_odd_settings;
    set_format(64'h7, 64'h38, 64'hC0, 64'h0, 2, 0, 3, 1'b0);
    send_byte(8'h12, 1'b1); send_byte(8'h34, 1'b0);
    cfg_write(mprc_pkg::REG_PBITS, 64'd0);   send_byte(8'h56, 1'b0);
    cfg_write(mprc_pkg::REG_PBITS, 64'd127); send_byte(8'h78, 1'b0);
    cfg_write(mprc_pkg::REG_PBITS, 64'd8);
    cfg_write(mprc_pkg::REG_WIDTH, 64'd0);   send_byte(8'h9A, 1'b1);
    cfg_write(mprc_pkg::REG_WIDTH, 64'h7FFF);
    cfg_write(mprc_pkg::REG_STRIDE, 64'h3FFFF);
    send_byte(8'hBC, 1'b1); send_byte(8'hDE, 1'b0);
    drain();
  endtask

  task automatic random_mask(int unsigned wbits, output logic [63:0] m);
    int unsigned sel, len;
    sel = $urandom_range(0, 9);
    len = $urandom_range(1, wbits);
    if (sel == 0) m = '0;
    else if (sel == 1) m = {$urandom, $urandom};
    else m = field_mask(len, $urandom_range(0, wbits - len));
  endtask

  task automatic test_random_images(int unsigned phases, int unsigned bytes);
    logic [63:0] r, g, b, a;
    int unsigned pb, wbits, wd, bpr, st, sel;
    for (int p = 0; p < phases; p++) begin
      sel = $urandom_range(0, 9);
      if (sel < 3) pb = 1 << sel;
      else if (sel < 9) pb = 8 * $urandom_range(1, 8);
      else pb = $urandom_range(0, 127);
      wbits = (pb < 8) ? 8 : (pb > 64) ? 64 : pb;
      random_mask(wbits, r); random_mask(wbits, g);
      random_mask(wbits, b); random_mask(wbits, a);
      wd = $urandom_range(1, 6);
      bpr = (wd * ((pb == 0) ? 8 : pb) + 7) / 8;
      st = ($urandom_range(0, 9) == 0) ? $urandom_range(1, bpr) : bpr + $urandom_range(0, 2);
      set_format(r, g, b, a, wd, st, pb, $urandom_range(0, 1));
      for (int i = 0; i < bytes; i++)
        send_byte(8'($urandom), (i == 0) || ($urandom_range(0, 29) == 0));
      // in the third phase only, hold off until the converter has caught up
      if (p == 2) drain();
      for (int i = 0; i < bytes / 2; i++) send_byte(8'($urandom), 1'b0);
      drain();
    end
  endtask

  initial begin
    mcfg = '0;
    mcfg.row_width = 1;
    mcfg.row_stride_bytes = 1;
    mcfg.pixel_bits = 8;
    asm_word = '0;
    asm_byte = 0;
    row_byte = 0;
    row_pix = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_format();
    test_rgb565();
    test_sub_byte();
    test_wide_pixels();
    test_odd_settings();
    test_random_images(8, 10);
    drain();
    if (!failed) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
